// ----- hw/rtl/iida_pkg.sv -----
// Shared types and constants for the indexed insert/delete array.
package iida_pkg;

    // Number of cells in the chain.
    localparam int DEPTH = 16;
    // Bits that address one cell.
    localparam int IDX_W = $clog2(DEPTH);
    // Width of the position and count fields.
    localparam int CNT_W = 5;
    // Width of one stored word.
    localparam int WORD_W = 32;

    typedef enum logic [2:0] {
        MODE_APPEND = 3'd0,
        MODE_INSERT = 3'd1,
        MODE_DELETE = 3'd2,
        MODE_DROP   = 3'd3,
        MODE_READ   = 3'd4
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2,
        ST_EMPTY = 2'd3
    } t_status;

    // Command broadcast to every cell; the strobes are already qualified
    // by acceptance and by the range, full and empty checks.
    typedef struct packed {
        logic                     append;
        logic                     insert;
        logic                     delete_at;
        logic [CNT_W-1:0]         pos;
        logic [CNT_W-1:0]         count;
        logic signed [WORD_W-1:0] value;
    } t_cell_cmd;

endpackage

// ----- hw/rtl/iida_cell.sv -----
// One storage cell of the chain: holds a word and takes it from the new value or a neighbor.
module iida_cell (
    input  logic                              i_clk,
    input  logic [iida_pkg::IDX_W-1:0]        i_index,
    input  iida_pkg::t_cell_cmd               i_cmd,
    input  logic signed [iida_pkg::WORD_W-1:0] i_left,
    input  logic signed [iida_pkg::WORD_W-1:0] i_right,
    output logic signed [iida_pkg::WORD_W-1:0] o_word
);
    import iida_pkg::*;

    logic signed [WORD_W-1:0] r_word;
    logic signed [WORD_W-1:0] n_word;
    logic [CNT_W-1:0]         index_ext;

    assign index_ext = CNT_W'(i_index);

    // An insert opens a gap at pos by moving the upper cells up one place;
    // a delete closes it by pulling the upper cells down one place.
    always_comb begin
        n_word = r_word;
        if (i_cmd.append && (index_ext == i_cmd.count)) begin
            n_word = i_cmd.value;
        end else if (i_cmd.insert) begin
            if (index_ext == i_cmd.pos) begin
                n_word = i_cmd.value;
            end else if (index_ext > i_cmd.pos) begin
                n_word = i_left;
            end
        end else if (i_cmd.delete_at && (index_ext >= i_cmd.pos)) begin
            n_word = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;

endmodule

// ----- hw/rtl/indexed_insert_delete_array_top.sv -----
// Top level of the indexed insert/delete array: handshakes, checks and the cell chain.
//
// Usage: each input word on the in channel (i_mode, i_position, i_value)
// asks for one operation on an ordered array of up to 16 signed words:
// append, insert at a position, delete at a position, drop the last entry,
// or read the entry at a position. Every accepted word gives exactly one
// result word on the out channel: a status, the word read (zero unless a
// read succeeded) and the entry count after the operation.
// The array lives in a chain of cells. On an insert or delete every cell
// at or above the position takes its new word from the incoming value or
// from a neighbor in the same clock. The result is registered and appears
// in the cycle after acceptance; the block sustains one word per cycle
// while the receiver keeps up. When the receiver stalls, the result is
// held in the output register and a new input word is taken only in a
// cycle in which that register is drained, so nothing is lost or repeated.
// The configuration channel writes the capacity limit at any time and is
// always ready; a value of zero acts as one and a value above 16 as 16.
// Synchronous reset empties the array (count zero), sets the capacity to 16
// and drops any pending result. Cell contents are not cleared; a cell is
// only ever read after it was written.
module indexed_insert_delete_array_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Configuration channel
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [iida_pkg::CNT_W-1:0]         i_cfg_capacity_limit,
    // Input channel
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [2:0]                         i_mode,
    input  logic [iida_pkg::CNT_W-1:0]         i_position,
    input  logic signed [iida_pkg::WORD_W-1:0] i_value,
    // Output channel
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [1:0]                         o_status,
    output logic signed [iida_pkg::WORD_W-1:0] o_read_word,
    output logic [iida_pkg::CNT_W-1:0]         o_entry_count
);
    import iida_pkg::*;

    logic [CNT_W-1:0]         r_cap_reg;
    logic [CNT_W-1:0]         r_count;
    logic [CNT_W-1:0]         n_count;
    logic                     r_out_valid;
    logic [1:0]               r_status;
    logic signed [WORD_W-1:0] r_read_word;
    logic [CNT_W-1:0]         r_entry_count;

    logic                     accept;
    logic [CNT_W-1:0]         cap;
    logic                     full;
    t_status                  status;
    logic signed [WORD_W-1:0] word;
    t_cell_cmd                cmd;
    logic signed [WORD_W-1:0] cell_word [DEPTH];

    assign o_cfg_ready = 1'b1;
    // The output register frees up in the same cycle it is drained.
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign accept      = i_in_valid && o_in_ready;

    // Capacity in use, clamped to 1..DEPTH.
    always_comb begin
        if (r_cap_reg == '0) begin
            cap = CNT_W'(1);
        end else if (r_cap_reg > CNT_W'(DEPTH)) begin
            cap = CNT_W'(DEPTH);
        end else begin
            cap = r_cap_reg;
        end
    end

    assign full = (r_count >= cap);

    // Decode the operation, run the checks and build the cell command.
    always_comb begin
        status        = ST_OK;
        word          = '0;
        n_count       = r_count;
        cmd.append    = 1'b0;
        cmd.insert    = 1'b0;
        cmd.delete_at = 1'b0;
        cmd.pos       = i_position;
        cmd.count     = r_count;
        cmd.value     = i_value;
        unique case (i_mode)
            MODE_APPEND: begin
                if (full) begin
                    status = ST_FULL;
                end else begin
                    cmd.append = accept;
                    n_count    = r_count + CNT_W'(1);
                end
            end
            MODE_INSERT: begin
                if (i_position > r_count) begin
                    status = ST_RANGE;
                end else if (full) begin
                    status = ST_FULL;
                end else begin
                    cmd.insert = accept;
                    n_count    = r_count + CNT_W'(1);
                end
            end
            MODE_DELETE: begin
                if (r_count == '0) begin
                    status = ST_EMPTY;
                end else if (i_position >= r_count) begin
                    status = ST_RANGE;
                end else begin
                    cmd.delete_at = accept;
                    n_count       = r_count - CNT_W'(1);
                end
            end
            MODE_DROP: begin
                if (r_count == '0) begin
                    status = ST_EMPTY;
                end else begin
                    n_count = r_count - CNT_W'(1);
                end
            end
            MODE_READ: begin
                if (i_position >= r_count) begin
                    status = ST_RANGE;
                end else begin
                    word = cell_word[i_position[IDX_W-1:0]];
                end
            end
            default: begin
                // Undefined modes do nothing and report success.
            end
        endcase
    end

    // The chain of cells. The ends see zero beyond the array; those words
    // only ever land in cells past the count.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic signed [WORD_W-1:0] left_word;
        logic signed [WORD_W-1:0] right_word;
        if (g == 0) begin : g_first
            assign left_word = '0;
        end else begin : g_inner_l
            assign left_word = cell_word[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign right_word = '0;
        end else begin : g_inner_r
            assign right_word = cell_word[g+1];
        end
        iida_cell u_cell (
            .i_clk   (i_clk),
            .i_index (IDX_W'(g)),
            .i_cmd   (cmd),
            .i_left  (left_word),
            .i_right (right_word),
            .o_word  (cell_word[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap_reg   <= CNT_W'(DEPTH);
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_cap_reg <= i_cfg_capacity_limit;
            end
            if (accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status      <= status;
            r_read_word   <= word;
            r_entry_count <= n_count;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_read_word   = r_read_word;
    assign o_entry_count = r_entry_count;

endmodule

// ----- dv/indexed_insert_delete_array_top_test.sv -----
// Self-checking testbench for the indexed insert/delete array top level.
`timescale 1ns / 1ps

module indexed_insert_delete_array_top_test;
    import iida_pkg::*;

    // Modes 5 to 7 have no operation behind them; the block must answer
    // them with an ok status and leave the array alone.
    localparam logic [2:0] MODE_SPARE_FIRST = 3'd5;
    localparam logic [2:0] MODE_SPARE_LAST  = 3'd7;

    // The limit lies far above the slowest correct run, so this
    // only trips on a hang.
    localparam int CYCLE_LIMIT = 200000;
    // Cycles the receiver refuses results in a row during the pressure test.
    localparam int LONG_HOLD_CYCLES = 64;

    typedef struct packed {
        logic [2:0]               mode;
        logic [CNT_W-1:0]         position;
        logic signed [WORD_W-1:0] value;
    } t_array_request;

    typedef struct packed {
        t_status                  status;
        logic signed [WORD_W-1:0] word;
        logic [CNT_W-1:0]         count;
    } t_array_result;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_cfg_valid = 1'b0;
    logic                     o_cfg_ready;
    logic [CNT_W-1:0]         i_cfg_capacity_limit = '0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_ready;
    logic [2:0]               i_mode = '0;
    logic [CNT_W-1:0]         i_position = '0;
    logic signed [WORD_W-1:0] i_value = '0;
    logic                     o_out_valid;
    logic                     i_out_ready = 1'b0;
    logic [1:0]               o_status;
    logic signed [WORD_W-1:0] o_read_word;
    logic [CNT_W-1:0]         o_entry_count;

    indexed_insert_delete_array_top u_dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_valid          (i_cfg_valid),
        .o_cfg_ready          (o_cfg_ready),
        .i_cfg_capacity_limit (i_cfg_capacity_limit),
        .i_in_valid           (i_in_valid),
        .o_in_ready           (o_in_ready),
        .i_mode               (i_mode),
        .i_position           (i_position),
        .i_value              (i_value),
        .o_out_valid          (o_out_valid),
        .i_out_ready          (i_out_ready),
        .o_status             (o_status),
        .o_read_word          (o_read_word),
        .o_entry_count        (o_entry_count)
    );

    // 8 ns period: four high, four low.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Words waiting to be offered on the input channel, and the results that
    // the accepted words still owe, oldest first.
    t_array_request queued_requests[$];
    t_array_result  owed_results[$];

    // Shadow copy of the array, its count and the capacity register.
    logic signed [WORD_W-1:0] held_words[DEPTH];
    int unsigned              held_count;
    logic [CNT_W-1:0]         capacity_reg;

    // Idle chances in percent for each side; the stimulus process changes
    // them between phases.
    int unsigned tx_idle_pct = 8;
    int unsigned rx_idle_pct = 51;

    int unsigned cycle_count = 0;
    int unsigned mismatch_count = 0;
    int unsigned cfg_writes = 0;
    logic        in_word_taken = 1'b0;
    logic        rx_hold = 1'b0;
    logic        long_hold_go = 1'b0;

    task automatic report_mismatch(input string what);
        $display("MISMATCH cycle %0d: %s", cycle_count, what);
        mismatch_count++;
    endtask

    // Applies one operation to the shadow array and returns the result that
    // the block has to give for it. A refused operation changes nothing.
    function automatic t_array_result apply_array_op(input logic [2:0] mode,
                                                     input logic [CNT_W-1:0] pos,
                                                     input logic signed [WORD_W-1:0] val);
        t_array_result res;
        int unsigned   cap;
        int unsigned   i;
        cap = capacity_reg;
        if (cap < 1) cap = 1;
        if (cap > DEPTH) cap = DEPTH;
        res.status = ST_OK;
        res.word = '0;
        case (mode)
            MODE_APPEND: begin
                if (held_count >= cap) begin
                    res.status = ST_FULL;
                end else begin
                    held_words[held_count] = val;
                    held_count++;
                end
            end
            MODE_INSERT: begin
                // The range check wins over the full check.
                if (pos > held_count) begin
                    res.status = ST_RANGE;
                end else if (held_count >= cap) begin
                    res.status = ST_FULL;
                end else begin
                    for (i = held_count; i > pos; i--) held_words[i] = held_words[i-1];
                    held_words[pos] = val;
                    held_count++;
                end
            end
            MODE_DELETE: begin
                if (held_count == 0) begin
                    res.status = ST_EMPTY;
                end else if (pos >= held_count) begin
                    res.status = ST_RANGE;
                end else begin
                    for (i = pos; i + 1 < held_count; i++) held_words[i] = held_words[i+1];
                    held_count--;
                end
            end
            MODE_DROP: begin
                if (held_count == 0) res.status = ST_EMPTY;
                else held_count--;
            end
            MODE_READ: begin
                if (pos >= held_count) res.status = ST_RANGE;
                else res.word = held_words[pos];
            end
            default: begin
            end
        endcase
        res.count = CNT_W'(held_count);
        return res;
    endfunction

    // Monitor: everything is sampled at the rising edge. A result is checked
    // before the word accepted in the same cycle is predicted, since a result
    // always belongs to an earlier word.
    always @(posedge i_clk) begin : monitor
        t_array_result want;
        cycle_count++;
        in_word_taken <= i_in_valid && o_in_ready;
        if (!i_rst_n) begin
            held_count = 0;
            capacity_reg = CNT_W'(DEPTH);
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (owed_results.size() == 0) begin
                    report_mismatch("result word with no request outstanding");
                end else begin
                    want = owed_results.pop_front();
                    if (o_status !== want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  o_status, want.status));
                    if (o_read_word !== want.word)
                        report_mismatch($sformatf("read word %0d, expected %0d",
                                                  o_read_word, want.word));
                    if (o_entry_count !== want.count)
                        report_mismatch($sformatf("entry count %0d, expected %0d",
                                                  o_entry_count, want.count));
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                capacity_reg = i_cfg_capacity_limit;
                cfg_writes++;
            end
            if (i_in_valid && o_in_ready)
                owed_results.push_back(apply_array_op(i_mode, i_position, i_value));
        end
    end

    // Driver: a word stays on the bus until it is taken. Once it is gone
    // (or nothing was offered) the next one goes out unless the sender
    // decides to idle this cycle. Each output gets at most one assignment.
    always @(negedge i_clk) begin : request_driver
        t_array_request req;
        logic           offer;
        if (i_rst_n && (!i_in_valid || in_word_taken)) begin
            offer = (queued_requests.size() != 0) && ($urandom_range(99) >= tx_idle_pct);
            if (offer) begin
                req = queued_requests.pop_front();
                i_mode <= req.mode;
                i_position <= req.position;
                i_value <= req.value;
            end
            i_in_valid <= offer;
        end
    end

    // Receiver: random back-pressure, or a flat refusal during the long hold.
    always @(negedge i_clk) begin : result_receiver
        if (rx_hold) begin
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Long receiver stall, counted here so that the sender keeps offering
    // words meanwhile: the output register fills and the input must stall.
    initial begin : long_receiver_hold
        wait (long_hold_go);
        @(negedge i_clk);
        rx_hold <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(negedge i_clk);
        rx_hold <= 1'b0;
    end

    // Watchdog: a hang or a lost result ends the run here.
    always @(posedge i_clk) begin
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("indexed_insert_delete_array_top regression: fail");
            $finish;
        end
    end

    function automatic void push_request(input logic [2:0] mode,
                                         input logic [CNT_W-1:0] pos,
                                         input logic signed [WORD_W-1:0] val);
        t_array_request req;
        req.mode = mode;
        req.position = pos;
        req.value = val;
        queued_requests.push_back(req);
    endfunction

    // Words with the sign bit, all zeros and all ones come up often, the
    // rest are fully random.
    function automatic logic signed [WORD_W-1:0] pick_word();
        case ($urandom_range(7))
            0: return 32'sh7fff_ffff;
            1: return 32'sh8000_0000;
            2: return '0;
            3: return '1;
            default: return $urandom;
        endcase
    endfunction

    // Random operations. Positions mostly fall around the legal range for
    // the capacity in use (span), and sometimes anywhere in the field.
    function automatic void push_random(input int unsigned n, input int unsigned span);
        int unsigned      k;
        int unsigned      roll;
        logic [2:0]       mode;
        logic [CNT_W-1:0] pos;
        for (k = 0; k < n; k++) begin
            roll = $urandom_range(99);
            if (roll < 25) mode = MODE_APPEND;
            else if (roll < 45) mode = MODE_INSERT;
            else if (roll < 65) mode = MODE_DELETE;
            else if (roll < 75) mode = MODE_DROP;
            else if (roll < 97) mode = MODE_READ;
            else mode = 3'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST));
            if ($urandom_range(99) < 85) pos = CNT_W'($urandom_range(span));
            else pos = CNT_W'($urandom_range(31));
            push_request(mode, pos, pick_word());
        end
    endfunction

    // Waits until every queued word was accepted and answered, then idles on
    // so the block is surely idle before a register write.
    task automatic wait_until_idle();
        while (queued_requests.size() != 0 || i_in_valid || owed_results.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Writes the capacity register and holds valid until the write is taken.
    task automatic write_capacity(input logic [CNT_W-1:0] cap);
        int unsigned seen;
        seen = cfg_writes;
        @(negedge i_clk);
        i_cfg_capacity_limit <= cap;
        i_cfg_valid <= 1'b1;
        while (cfg_writes == seen) @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Starts a phase on a rising edge, so the driver and the receiver see
    // the new queue and idle chances at their next falling edge without a race.
    task automatic start_phase(input int unsigned tx_pct, input int unsigned rx_pct,
                               input int unsigned n, input int unsigned span);
        @(posedge i_clk);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        push_random(n, span);
    endtask

    initial begin : stimulus
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part with the reset capacity of 16: every refusal on an
        // empty array, inserts at the front, middle and end, the value
        // extremes, out-of-range positions up to all ones, and the unused modes.
        @(posedge i_clk);
        push_request(MODE_READ,   5'd0,  '0);
        push_request(MODE_DELETE, 5'd0,  '0);
        push_request(MODE_DROP,   5'd0,  '0);
        push_request(MODE_INSERT, 5'd1,  32'sh1234_5678);
        push_request(MODE_INSERT, 5'd0,  32'sh7fff_ffff);
        push_request(MODE_APPEND, 5'd0,  32'sh8000_0000);
        push_request(MODE_APPEND, 5'd31, '0);
        push_request(MODE_INSERT, 5'd3,  '1);
        push_request(MODE_INSERT, 5'd1,  32'sh5a5a_a5a5);
        push_request(MODE_READ,   5'd1,  '0);
        push_request(MODE_READ,   5'd4,  '0);
        push_request(MODE_READ,   5'd5,  '0);
        push_request(MODE_DELETE, 5'd5,  '0);
        push_request(MODE_DELETE, 5'd0,  '0);
        push_request(MODE_DROP,   5'd0,  '0);
        push_request(MODE_READ,   5'd31, '0);
        push_request(MODE_INSERT, 5'd31, 32'sh0f0f_0f0f);
        push_request(MODE_DELETE, 5'd31, '0);
        push_request(MODE_SPARE_FIRST,  5'd0, '1);
        push_request(MODE_SPARE_FIRST + 3'd1, 5'd2, '1);
        push_request(MODE_SPARE_LAST,   5'd1, '1);
        push_request(MODE_READ,   5'd0,  '0);
        push_request(MODE_READ,   5'd2,  '0);
        wait_until_idle();

        // A small capacity makes the full refusals common.
        write_capacity(5'd2);
        start_phase(8, 51, 150, 3);
        wait_until_idle();

        // Zero acts as a capacity of one. From here the receiver is the
        // side that stalls rarely and the sender idles often.
        write_capacity(5'd0);
        start_phase(51, 8, 100, 2);
        wait_until_idle();

        // Above the depth acts as the full depth.
        write_capacity(5'd31);
        start_phase(51, 8, 200, 17);
        wait_until_idle();

        // No idling on either side, apart from one long receiver stall
        // while the sender keeps pushing.
        write_capacity(5'd16);
        start_phase(0, 0, 200, 17);
        long_hold_go = 1'b1;
        wait_until_idle();

        // Lowering the capacity below the entries held: they stay, and
        // growth is refused until the count falls below the new limit.
        write_capacity(5'd3);
        start_phase(0, 0, 100, 4);
        wait_until_idle();

        write_capacity(5'd1);
        start_phase(0, 0, 50, 2);
        wait_until_idle();

        if (mismatch_count == 0) begin
            $display("indexed_insert_delete_array_top regression: pass");
        end else begin
            $display("indexed_insert_delete_array_top regression: fail");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/iida_pkg.sv
hw/rtl/iida_cell.sv
hw/rtl/indexed_insert_delete_array_top.sv
dv/indexed_insert_delete_array_top_test.sv
